// ===== hw/rtl/range_value_count_table_core_defines.svh =====
// Assertion macros for the range value count table core.
// Included by rvct_ctrl, which carries concurrent checks; no other dependencies.
`ifndef RANGE_VALUE_COUNT_TABLE_CORE_DEFINES_SVH
`define RANGE_VALUE_COUNT_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RVCT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define RVCT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication violated");

`endif

// ===== hw/rtl/rvct_pkg.sv =====
// Shared types and constants for the range value count table core.
// No dependencies; used by the interfaces, controller, datapath and top level.
package rvct_pkg;

   // Field widths of the transfer payloads
   localparam int MODE_BITS      = 2;
   localparam int SEL_BITS       = 1;
   localparam int POS_BITS       = 10;
   localparam int VAL_FIELD_BITS = 16;
   localparam int COUNT_BITS     = 11;

   // Default sizing
   localparam int ENTRIES_DEF    = 1024;
   localparam int VALUE_BITS_DEF = 16;
   localparam int TABLES_DEF     = 2;

   // Slots per memory word
   localparam int LANES     = 16;
   localparam int LANE_BITS = $clog2(LANES);

   // Operation codes
   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ERASE  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_QUERY  = 2'd2;

   typedef struct packed {
      logic [MODE_BITS-1:0]      mode;
      logic [SEL_BITS-1:0]       table_sel;
      logic [POS_BITS-1:0]       position;
      logic [VAL_FIELD_BITS-1:0] value;
      logic [POS_BITS-1:0]       index_lo;
      logic [POS_BITS-1:0]       index_hi;
      logic [VAL_FIELD_BITS-1:0] value_lo;
      logic [VAL_FIELD_BITS-1:0] value_hi;
   } req_payload_type;

   // Controller -> datapath
   typedef struct packed {
      logic capture;     // latch request fields
      logic clr_write;   // write an empty word at the sweep address
      logic rmw_read;    // read the row holding the addressed slot
      logic rmw_write;   // write that row back, slot updated
      logic scan_start;  // load first query row, clear the count
      logic scan_read;   // read the current query row, advance
      logic rsp_load;    // load the result register
      logic rsp_zero;    // result is zero rather than the count
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic                 slot_ok;      // table and position in range
      logic                 query_empty;  // nothing can match
      logic                 sweep_last;
      logic                 scan_last;
      logic                 pipe_busy;    // query rows still in flight
      logic                 rsp_free;     // result register can take a value
   } status_type;

endpackage

// ===== hw/rtl/rvct_req_if.sv =====
// Request channel interface: valid/ready handshake plus the request fields.
// Depends on rvct_pkg for field widths.
interface rvct_req_if;
   logic                                valid;
   logic                                ready;
   logic [rvct_pkg::MODE_BITS-1:0]      mode;
   logic [rvct_pkg::SEL_BITS-1:0]       table_sel;
   logic [rvct_pkg::POS_BITS-1:0]       position;
   logic [rvct_pkg::VAL_FIELD_BITS-1:0] value;
   logic [rvct_pkg::POS_BITS-1:0]       index_lo;
   logic [rvct_pkg::POS_BITS-1:0]       index_hi;
   logic [rvct_pkg::VAL_FIELD_BITS-1:0] value_lo;
   logic [rvct_pkg::VAL_FIELD_BITS-1:0] value_hi;

   modport source (
      output valid, mode, table_sel, position, value, index_lo, index_hi, value_lo, value_hi,
      input  ready
   );

   modport sink (
      input  valid, mode, table_sel, position, value, index_lo, index_hi, value_lo, value_hi,
      output ready
   );
endinterface

// ===== hw/rtl/rvct_rsp_if.sv =====
// Response channel interface: valid/ready handshake plus the match count.
// Depends on rvct_pkg for the field width.
interface rvct_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rvct_pkg::COUNT_BITS-1:0] match_count;

   modport source (output valid, match_count, input ready);
   modport sink   (input valid, match_count, output ready);
endinterface

// ===== hw/rtl/rvct_ctrl.sv =====
// Sequencing FSM for the range value count table core.
// Depends on rvct_pkg and range_value_count_table_core_defines.svh.
`include "range_value_count_table_core_defines.svh"

module rvct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rvct_pkg::status_type status,
   output rvct_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_RMW_RD = 3'd3;
   localparam logic [2:0] S_RMW_WR = 3'd4;
   localparam logic [2:0] S_SCAN   = 3'd5;
   localparam logic [2:0] S_DRAIN  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      cmd.rsp_zero = (status.mode != rvct_pkg::MODE_QUERY) || status.query_empty;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.mode)
               rvct_pkg::MODE_INSERT,
               rvct_pkg::MODE_ERASE: begin
                  state_in = status.slot_ok ? S_RMW_RD : S_DONE;
               end
               rvct_pkg::MODE_QUERY: begin
                  if (status.query_empty) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RMW_RD: begin
            cmd.rmw_read = 1'b1;
            state_in     = S_RMW_WR;
         end
         S_RMW_WR: begin
            cmd.rmw_write = 1'b1;
            state_in      = S_DONE;
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // clearing pass runs once per reset
   `RVCT_ASSERT_NEXT(a_clear_once, clock, reset, state_ff != S_CLEAR, state_ff != S_CLEAR)
   // count must be final before the result is loaded
   `RVCT_ASSERT_IMPLIES(a_done_drained, clock, reset, state_ff == S_DONE, !status.pipe_busy)
   // write-back only right after the row read
   `RVCT_ASSERT_IMPLIES(a_rmw_order, clock, reset, cmd.rmw_write, $past(cmd.rmw_read))

endmodule

// ===== hw/rtl/rvct_dp.sv =====
// Datapath: slot memory, request registers, query scan pipeline, result register.
// Depends on rvct_pkg; driven by rvct_ctrl through cmd_type/status_type.
module rvct_dp #(
   parameter int ENTRIES    = rvct_pkg::ENTRIES_DEF,
   parameter int VALUE_BITS = rvct_pkg::VALUE_BITS_DEF,
   parameter int TABLES     = rvct_pkg::TABLES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rvct_pkg::req_payload_type       req,
   input  rvct_pkg::cmd_type               cmd,
   output rvct_pkg::status_type            status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rvct_pkg::COUNT_BITS-1:0] rsp_match_count
);

   localparam int LANES     = rvct_pkg::LANES;
   localparam int LANE_BITS = rvct_pkg::LANE_BITS;
   localparam int POS_BITS  = rvct_pkg::POS_BITS;
   localparam int VF_BITS   = rvct_pkg::VAL_FIELD_BITS;
   localparam int CNT_BITS  = rvct_pkg::COUNT_BITS;
   localparam int ROWS      = (ENTRIES + LANES - 1) / LANES;
   localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int MEM_DEPTH = TABLES * (2 ** ROW_BITS);
   localparam int ADDR_BITS = $clog2(MEM_DEPTH);
   localparam int CMP_BITS  = (VALUE_BITS > VF_BITS) ? VALUE_BITS : VF_BITS;
   localparam int unsigned LAST_IDX = ENTRIES - 1;

   typedef logic [LANES-1:0][VALUE_BITS:0] word_type;  // per lane: {occupied, value}

   word_type mem [MEM_DEPTH];

   // request registers
   logic [rvct_pkg::MODE_BITS-1:0] mode_ff;
   logic [rvct_pkg::SEL_BITS-1:0]  tsel_ff;
   logic [POS_BITS-1:0]            pos_ff;
   logic [VALUE_BITS-1:0]          val_ff;
   logic [POS_BITS-1:0]            lo_ff;
   logic [POS_BITS-1:0]            hi_ff;    // clamped to the last slot
   logic [VF_BITS-1:0]             vlo_ff;
   logic [VF_BITS-1:0]             vhi_ff;
   logic                           slot_ok_ff;
   logic                           qempty_ff;
   logic [POS_BITS-1:0]            hi_clamp;

   // memory access
   logic [ADDR_BITS-1:0] sweep_ff;
   logic [ROW_BITS-1:0]  scan_row_ff;
   logic [ROW_BITS-1:0]  pos_row;
   logic [ROW_BITS-1:0]  lo_row;
   logic [ROW_BITS-1:0]  hi_row;
   logic [ADDR_BITS-1:0] rmw_addr;
   logic [ADDR_BITS-1:0] scan_addr;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [ADDR_BITS-1:0] wr_addr;
   word_type             wr_data;
   word_type             new_word;
   word_type             rd_data_ff;
   logic                 mem_we;
   logic                 mem_re;

   // scan pipeline
   logic                rd_scan_ff;
   logic [ROW_BITS-1:0] rd_row_ff;
   logic [LANES-1:0]    hit_in;
   logic [LANES-1:0]    hit_ff;
   logic                hit_vld_ff;
   logic [CNT_BITS-1:0] acc_ff;
   logic [CNT_BITS:0]   acc_sum;

   // result register
   logic                rsp_valid_ff;
   logic [CNT_BITS-1:0] rsp_count_ff;

   assign hi_clamp = (32'(req.index_hi) > LAST_IDX) ? POS_BITS'(LAST_IDX) : req.index_hi;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= req.mode;
         tsel_ff    <= req.table_sel;
         pos_ff     <= req.position;
         val_ff     <= VALUE_BITS'(req.value);
         lo_ff      <= req.index_lo;
         hi_ff      <= hi_clamp;
         vlo_ff     <= req.value_lo;
         vhi_ff     <= req.value_hi;
         slot_ok_ff <= (32'(req.table_sel) < 32'(TABLES)) && (32'(req.position) < 32'(ENTRIES));
         qempty_ff  <= (32'(req.table_sel) >= 32'(TABLES)) || (req.index_lo > hi_clamp);
      end
   end

   assign pos_row   = ROW_BITS'(pos_ff >> LANE_BITS);
   assign lo_row    = ROW_BITS'(lo_ff >> LANE_BITS);
   assign hi_row    = ROW_BITS'(hi_ff >> LANE_BITS);
   assign rmw_addr  = ADDR_BITS'({tsel_ff, pos_row});
   assign scan_addr = ADDR_BITS'({tsel_ff, scan_row_ff});

   // insert sets the lane, erase drops its occupied bit
   always_comb begin
      new_word = rd_data_ff;
      if (mode_ff == rvct_pkg::MODE_INSERT) begin
         new_word[pos_ff[LANE_BITS-1:0]] = {1'b1, val_ff};
      end else begin
         new_word[pos_ff[LANE_BITS-1:0]][VALUE_BITS] = 1'b0;
      end
   end

   assign mem_we  = cmd.clr_write || cmd.rmw_write;
   assign mem_re  = cmd.scan_read || cmd.rmw_read;
   assign wr_addr = cmd.clr_write ? sweep_ff : rmw_addr;
   assign wr_data = cmd.clr_write ? '0 : new_word;
   assign rd_addr = cmd.scan_read ? scan_addr : rmw_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.clr_write) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_row_ff <= lo_row;
      end else if (cmd.scan_read) begin
         scan_row_ff <= scan_row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_scan_ff <= 1'b0;
         hit_vld_ff <= 1'b0;
      end else begin
         rd_scan_ff <= cmd.scan_read;
         hit_vld_ff <= rd_scan_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_read) begin
         rd_row_ff <= scan_row_ff;
      end
      if (rd_scan_ff) begin
         hit_ff <= hit_in;
      end
   end

   // lane match: occupied, inside the index window, inside the value window
   always_comb begin
      logic [CMP_BITS-1:0] v;
      logic                lane_ge;
      logic                lane_le;
      for (int j = 0; j < LANES; j++) begin
         v       = CMP_BITS'(rd_data_ff[j][VALUE_BITS-1:0]);
         lane_ge = (rd_row_ff != lo_row) || (LANE_BITS'(j) >= lo_ff[LANE_BITS-1:0]);
         lane_le = (rd_row_ff != hi_row) || (LANE_BITS'(j) <= hi_ff[LANE_BITS-1:0]);
         hit_in[j] = rd_data_ff[j][VALUE_BITS] && lane_ge && lane_le &&
                     (v >= CMP_BITS'(vlo_ff)) && (v <= CMP_BITS'(vhi_ff));
      end
   end

   assign acc_sum = (CNT_BITS + 1)'(acc_ff) + (CNT_BITS + 1)'($countones(hit_ff));

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         acc_ff <= '0;
      end else if (hit_vld_ff) begin
         acc_ff <= acc_sum[CNT_BITS] ? '1 : acc_sum[CNT_BITS-1:0];  // saturate
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_count_ff <= cmd.rsp_zero ? '0 : acc_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_count = rsp_count_ff;

   assign status.mode        = mode_ff;
   assign status.slot_ok     = slot_ok_ff;
   assign status.query_empty = qempty_ff;
   assign status.sweep_last  = (sweep_ff == ADDR_BITS'(MEM_DEPTH - 1));
   assign status.scan_last   = (scan_row_ff == hi_row);
   assign status.pipe_busy   = rd_scan_ff || hit_vld_ff;
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

endmodule

// ===== hw/rtl/range_value_count_table_core.sv =====
// Top level of the range value count table core: controller plus datapath.
// Depends on rvct_pkg, rvct_req_if, rvct_rsp_if, rvct_ctrl and rvct_dp.
//
//   channel    | direction | payload
//   -----------+-----------+----------------------------------------------------
//   req_chan   | in        | mode, table_sel, position, value, index/value windows
//   rsp_chan   | out       | match_count (one transfer per request)
//
// Steps: insert or erase: decode, row read, write-back, result load (slot out of range:
//   decode, result load); mode 3 and a query with an empty window: decode, result load;
//   a query: decode, row scan, drain, result load, reading one 16-slot row per cycle.
// Reset: synchronous; a clearing pass then writes TABLES * 2**ROW_BITS rows, 128 at the
//   default sizing, with req_chan.ready low.
// Stalls: a request may be taken while an older result waits; its result then waits too.
module range_value_count_table_core #(
   parameter int ENTRIES    = rvct_pkg::ENTRIES_DEF,
   parameter int VALUE_BITS = rvct_pkg::VALUE_BITS_DEF,
   parameter int TABLES     = rvct_pkg::TABLES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rvct_req_if.sink   req_chan,
   rvct_rsp_if.source rsp_chan
);

   rvct_pkg::req_payload_type req_payload;
   rvct_pkg::cmd_type         cmd;
   rvct_pkg::status_type      status;
   logic                      req_ready;

   // gather request fields into one bundle for the datapath
   assign req_payload.mode      = req_chan.mode;
   assign req_payload.table_sel = req_chan.table_sel;
   assign req_payload.position  = req_chan.position;
   assign req_payload.value     = req_chan.value;
   assign req_payload.index_lo  = req_chan.index_lo;
   assign req_payload.index_hi  = req_chan.index_hi;
   assign req_payload.value_lo  = req_chan.value_lo;
   assign req_payload.value_hi  = req_chan.value_hi;

   assign req_chan.ready = req_ready;

   // sequencing: clear sweep, decode, read-modify-write or row scan, result load
   rvct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // slot memory, scan pipeline and output register
   rvct_dp #(
      .ENTRIES    (ENTRIES),
      .VALUE_BITS (VALUE_BITS),
      .TABLES     (TABLES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req             (req_payload),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_match_count (rsp_chan.match_count)
   );

endmodule
